[hw/rtl/rvap_pkg.sv]
// ----------------------------------------------------------------------------
// rvap_pkg
// Widths shared by the reflection pipeline, its multiplier and divider chains.
// ----------------------------------------------------------------------------
package rvap_pkg;

	// Input and output components.
	localparam int IW  = 32;
	// Point differences.
	localparam int EW  = IW + 1;
	// Plane normal components.
	localparam int NW  = 2 * EW + 1;
	// Squared length of the normal, never negative.
	localparam int DDW = 2 * NW;
	// Dot product of the vector and the normal.
	localparam int VNW = 100;
	// Numerator v*dd - 2*vn*n of one component.
	localparam int MW  = 168;
	// Rounded numerator and remainder in the divider.
	localparam int RW  = MW + 2;
	// Divisor 2*dd.
	localparam int DW  = DDW;
	// Quotient magnitude bits; the result never exceeds 2^34 in size.
	localparam int QW  = 35;
	// Chunk width of the multiplier cells.
	localparam int CW  = 32;

	localparam logic [IW-1:0] SAT_POS = {1'b0, {(IW-1){1'b1}}};
	localparam logic [IW-1:0] SAT_NEG = {1'b1, {(IW-1){1'b0}}};

	typedef logic signed [IW-1:0] word_t;

endpackage

[hw/rtl/rvap_mul_cell.sv]
// ----------------------------------------------------------------------------
// rvap_mul_cell
// One cell of a multiplier chain: adds one chunk-by-chunk partial product.
// ----------------------------------------------------------------------------
module rvap_mul_cell #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int CW = 32,
	parameter int WS = 1,
	parameter int NA = 1,
	parameter int NB = 1,
	parameter int IA = 0,
	parameter int IB = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic signed [WA-1:0]    a_i,
	input  logic signed [WB-1:0]    b_i,
	input  logic signed [WA+WB-1:0] acc_i,
	input  logic [WS-1:0]           side_i,
	output logic                    vld_o,
	output logic signed [WA-1:0]    a_o,
	output logic signed [WB-1:0]    b_o,
	output logic signed [WA+WB-1:0] acc_o,
	output logic [WS-1:0]           side_o
);

	localparam int WP  = WA + WB;
	localparam int WEA = NA * CW;
	localparam int WEB = NB * CW;
	localparam int SH  = CW * (IA + IB);

	logic signed [WEA-1:0]    a_ext;
	logic signed [WEB-1:0]    b_ext;
	logic signed [CW:0]       ca;
	logic signed [CW:0]       cb;
	logic signed [2*CW+1:0]   pp;
	logic signed [WP-1:0]     pp_w;
	logic                     vld_q;
	logic signed [WA-1:0]     a_q;
	logic signed [WB-1:0]     b_q;
	logic signed [WP-1:0]     acc_q;
	logic [WS-1:0]            side_q;

	// The top chunk of each operand carries the sign, the others are unsigned.
	always_comb begin
		a_ext = WEA'(a_i);
		b_ext = WEB'(b_i);
		if (IA == NA - 1) begin
			ca = {a_ext[IA*CW+CW-1], a_ext[IA*CW +: CW]};
		end else begin
			ca = {1'b0, a_ext[IA*CW +: CW]};
		end
		if (IB == NB - 1) begin
			cb = {b_ext[IB*CW+CW-1], b_ext[IB*CW +: CW]};
		end else begin
			cb = {1'b0, b_ext[IB*CW +: CW]};
		end
		pp   = ca * cb;
		pp_w = WP'(pp) <<< SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_q    <= a_i;
			b_q    <= b_i;
			acc_q  <= acc_i + pp_w;
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign a_o    = a_q;
	assign b_o    = b_q;
	assign acc_o  = acc_q;
	assign side_o = side_q;

endmodule

[hw/rtl/rvap_mul.sv]
// ----------------------------------------------------------------------------
// rvap_mul
// Signed multiplier built as a chain of cells, one partial product per cell.
// ----------------------------------------------------------------------------
module rvap_mul #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int CW = 32,
	parameter int WS = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic signed [WA-1:0]    a_i,
	input  logic signed [WB-1:0]    b_i,
	input  logic [WS-1:0]           side_i,
	output logic                    vld_o,
	output logic signed [WA+WB-1:0] p_o,
	output logic [WS-1:0]           side_o
);

	localparam int NA = (WA + CW - 1) / CW;
	localparam int NB = (WB + CW - 1) / CW;
	localparam int NC = NA * NB;
	localparam int WP = WA + WB;

	logic                 vld_w  [NC+1];
	logic signed [WA-1:0] a_w    [NC];
	logic signed [WB-1:0] b_w    [NC];
	logic signed [WP-1:0] acc_w  [NC+1];
	logic [WS-1:0]        side_w [NC+1];

	assign vld_w[0]  = vld_i;
	assign a_w[0]    = a_i;
	assign b_w[0]    = b_i;
	assign acc_w[0]  = '0;
	assign side_w[0] = side_i;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		if (k < NC - 1) begin : g_mid
			rvap_mul_cell #(
				.WA(WA), .WB(WB), .CW(CW), .WS(WS),
				.NA(NA), .NB(NB), .IA(k / NB), .IB(k % NB)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(vld_w[k]), .a_i(a_w[k]), .b_i(b_w[k]),
				.acc_i(acc_w[k]), .side_i(side_w[k]),
				.vld_o(vld_w[k+1]), .a_o(a_w[k+1]), .b_o(b_w[k+1]),
				.acc_o(acc_w[k+1]), .side_o(side_w[k+1])
			);
		end else begin : g_last
			rvap_mul_cell #(
				.WA(WA), .WB(WB), .CW(CW), .WS(WS),
				.NA(NA), .NB(NB), .IA(k / NB), .IB(k % NB)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(vld_w[k]), .a_i(a_w[k]), .b_i(b_w[k]),
				.acc_i(acc_w[k]), .side_i(side_w[k]),
				.vld_o(vld_w[k+1]), .a_o(), .b_o(),
				.acc_o(acc_w[k+1]), .side_o(side_w[k+1])
			);
		end
	end

	assign vld_o  = vld_w[NC];
	assign p_o    = acc_w[NC];
	assign side_o = side_w[NC];

endmodule

[hw/rtl/rvap_div_cell.sv]
// ----------------------------------------------------------------------------
// rvap_div_cell
// One cell of the restoring divider chain: settles one quotient bit.
// ----------------------------------------------------------------------------
module rvap_div_cell #(
	parameter int RW = 170,
	parameter int DW = 134,
	parameter int QW = 35,
	parameter int WS = 1,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [RW-1:0] rem_i,
	input  logic [DW-1:0] den_i,
	input  logic [QW-1:0] q_i,
	input  logic [WS-1:0] side_i,
	output logic          vld_o,
	output logic [RW-1:0] rem_o,
	output logic [DW-1:0] den_o,
	output logic [QW-1:0] q_o,
	output logic [WS-1:0] side_o
);

	logic [RW-1:0] dsh;
	logic          ge;
	logic          vld_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic [WS-1:0] side_q;

	assign dsh = RW'(den_i) << K;
	assign ge  = rem_i >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? rem_i - dsh : rem_i;
			den_q  <= den_i;
			q_q    <= q_i | (ge ? (QW'(1) << K) : '0);
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign den_o  = den_q;
	assign q_o    = q_q;
	assign side_o = side_q;

endmodule

[hw/rtl/rvap_div.sv]
// ----------------------------------------------------------------------------
// rvap_div
// Unsigned divider as a chain of cells, most significant quotient bit first.
// The numerator must be below den * 2^QW.
// ----------------------------------------------------------------------------
module rvap_div #(
	parameter int RW = 170,
	parameter int DW = 134,
	parameter int QW = 35,
	parameter int WS = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [RW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [WS-1:0] side_i,
	output logic          vld_o,
	output logic [QW-1:0] q_o,
	output logic [WS-1:0] side_o
);

	logic          vld_w  [QW+1];
	logic [RW-1:0] rem_w  [QW];
	logic [DW-1:0] den_w  [QW];
	logic [QW-1:0] q_w    [QW+1];
	logic [WS-1:0] side_w [QW+1];

	assign vld_w[0]  = vld_i;
	assign rem_w[0]  = num_i;
	assign den_w[0]  = den_i;
	assign q_w[0]    = '0;
	assign side_w[0] = side_i;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		if (k < QW - 1) begin : g_mid
			rvap_div_cell #(
				.RW(RW), .DW(DW), .QW(QW), .WS(WS), .K(QW - 1 - k)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(vld_w[k]), .rem_i(rem_w[k]), .den_i(den_w[k]),
				.q_i(q_w[k]), .side_i(side_w[k]),
				.vld_o(vld_w[k+1]), .rem_o(rem_w[k+1]), .den_o(den_w[k+1]),
				.q_o(q_w[k+1]), .side_o(side_w[k+1])
			);
		end else begin : g_last
			rvap_div_cell #(
				.RW(RW), .DW(DW), .QW(QW), .WS(WS), .K(QW - 1 - k)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(vld_w[k]), .rem_i(rem_w[k]), .den_i(den_w[k]),
				.q_i(q_w[k]), .side_i(side_w[k]),
				.vld_o(vld_w[k+1]), .rem_o(), .den_o(),
				.q_o(q_w[k+1]), .side_o(side_w[k+1])
			);
		end
	end

	assign vld_o  = vld_w[QW];
	assign q_o    = q_w[QW];
	assign side_o = side_w[QW];

endmodule

[hw/rtl/reflect_vector_about_plane_unit.sv]
// ----------------------------------------------------------------------------
// reflect_vector_about_plane_unit
// Reflects a vector about the plane through three points:
// r = v - 2 (v.n) n / (n.n), n = (b - a) x (c - a), rounded and saturated.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Word
// input     in_valid / in_ready    vec_*, plane_a_*, plane_b_*, plane_c_*
// output    out_valid / out_ready  refl_*, degenerate, saturated
//
// One word enters per cycle while the output is not stalled; the depth is
// set mostly by the 20-cell multiplier chains and the 35-cell divider chain.
// The whole pipeline moves together and halts only while the output
// register holds a word that is not taken.
// Reset clears the valid bits only.
//
module reflect_vector_about_plane_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	input  logic [31:0] plane_a_x,
	input  logic [31:0] plane_a_y,
	input  logic [31:0] plane_a_z,
	input  logic [31:0] plane_b_x,
	input  logic [31:0] plane_b_y,
	input  logic [31:0] plane_b_z,
	input  logic [31:0] plane_c_x,
	input  logic [31:0] plane_c_y,
	input  logic [31:0] plane_c_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] refl_x,
	output logic [31:0] refl_y,
	output logic [31:0] refl_z,
	output logic        degenerate,
	output logic        saturated
);

	localparam int IW  = rvap_pkg::IW;
	localparam int EW  = rvap_pkg::EW;
	localparam int NW  = rvap_pkg::NW;
	localparam int DDW = rvap_pkg::DDW;
	localparam int VNW = rvap_pkg::VNW;
	localparam int MW  = rvap_pkg::MW;
	localparam int RW  = rvap_pkg::RW;
	localparam int DW  = rvap_pkg::DW;
	localparam int QW  = rvap_pkg::QW;
	localparam int CW  = rvap_pkg::CW;
	localparam int VPW = 3 * IW;
	localparam int P1W = 2 * EW;
	localparam int P2W = 2 * NW;
	localparam int P3W = VNW + DDW;
	localparam int S2W = VPW + 3 * NW;
	localparam int S3W = VPW + DDW;
	localparam int S4W = 3 + 1 + VPW;

	logic en;

	rvap_pkg::word_t v_in [3];
	rvap_pkg::word_t a_in [3];
	rvap_pkg::word_t b_in [3];
	rvap_pkg::word_t c_in [3];

	assign v_in[0] = vec_x;
	assign v_in[1] = vec_y;
	assign v_in[2] = vec_z;
	assign a_in[0] = plane_a_x;
	assign a_in[1] = plane_a_y;
	assign a_in[2] = plane_a_z;
	assign b_in[0] = plane_b_x;
	assign b_in[1] = plane_b_y;
	assign b_in[2] = plane_b_z;
	assign c_in[0] = plane_c_x;
	assign c_in[1] = plane_c_y;
	assign c_in[2] = plane_c_z;

	// The pipeline advances whenever the output register is free or drains.
	logic out_vld_q;
	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	// ------------------------------------------------------------ differences
	logic                 vld_s1;
	logic signed [EW-1:0] e_s1 [3];
	logic signed [EW-1:0] f_s1 [3];
	logic [VPW-1:0]       v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i] <= EW'(b_in[i]) - EW'(a_in[i]);
				f_s1[i] <= EW'(c_in[i]) - EW'(a_in[i]);
			end
			v_s1 <= {v_in[2], v_in[1], v_in[0]};
		end
	end

	// ------------------------------------------------------ cross products
	logic signed [EW-1:0]  g1_a [6];
	logic signed [EW-1:0]  g1_b [6];
	logic signed [P1W-1:0] g1_p [6];
	logic                  g1_vld;
	logic [VPW-1:0]        g1_side;

	always_comb begin
		g1_a[0] = e_s1[1]; g1_b[0] = f_s1[2];
		g1_a[1] = e_s1[2]; g1_b[1] = f_s1[1];
		g1_a[2] = e_s1[2]; g1_b[2] = f_s1[0];
		g1_a[3] = e_s1[0]; g1_b[3] = f_s1[2];
		g1_a[4] = e_s1[0]; g1_b[4] = f_s1[1];
		g1_a[5] = e_s1[1]; g1_b[5] = f_s1[0];
	end

	for (genvar k = 0; k < 6; k++) begin : g_cross
		if (k == 0) begin : g_lead
			rvap_mul #(.WA(EW), .WB(EW), .CW(EW), .WS(VPW)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s1),
				.a_i(g1_a[k]), .b_i(g1_b[k]), .side_i(v_s1),
				.vld_o(g1_vld), .p_o(g1_p[k]), .side_o(g1_side)
			);
		end else begin : g_rest
			rvap_mul #(.WA(EW), .WB(EW), .CW(EW), .WS(1)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s1),
				.a_i(g1_a[k]), .b_i(g1_b[k]), .side_i(1'b0),
				.vld_o(), .p_o(g1_p[k]), .side_o()
			);
		end
	end

	logic                 vld_s2;
	logic signed [NW-1:0] n_s2 [3];
	logic [VPW-1:0]       v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= g1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s2[i] <= NW'(g1_p[2*i]) - NW'(g1_p[2*i+1]);
			end
			v_s2 <= g1_side;
		end
	end

	// ------------------------------------------- squared length, dot product
	logic signed [NW-1:0]  g2_a [6];
	logic signed [NW-1:0]  g2_b [6];
	logic signed [P2W-1:0] g2_p [6];
	logic                  g2_vld;
	logic [S2W-1:0]        g2_side;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			g2_a[i]   = n_s2[i];
			g2_b[i]   = n_s2[i];
			g2_a[i+3] = NW'($signed(v_s2[i*IW +: IW]));
			g2_b[i+3] = n_s2[i];
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_dot
		if (k == 0) begin : g_lead
			rvap_mul #(.WA(NW), .WB(NW), .CW(CW), .WS(S2W)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
				.a_i(g2_a[k]), .b_i(g2_b[k]),
				.side_i({n_s2[2], n_s2[1], n_s2[0], v_s2}),
				.vld_o(g2_vld), .p_o(g2_p[k]), .side_o(g2_side)
			);
		end else begin : g_rest
			rvap_mul #(.WA(NW), .WB(NW), .CW(CW), .WS(1)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s2),
				.a_i(g2_a[k]), .b_i(g2_b[k]), .side_i(1'b0),
				.vld_o(), .p_o(g2_p[k]), .side_o()
			);
		end
	end

	logic                  vld_s3;
	logic signed [DDW-1:0] dd_s3;
	logic signed [VNW-1:0] vn_s3;
	logic signed [NW-1:0]  n_s3 [3];
	logic [VPW-1:0]        v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= g2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s3 <= DDW'(g2_p[0]) + DDW'(g2_p[1]) + DDW'(g2_p[2]);
			vn_s3 <= VNW'(g2_p[3]) + VNW'(g2_p[4]) + VNW'(g2_p[5]);
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= g2_side[VPW + i*NW +: NW];
			end
			v_s3 <= g2_side[VPW-1:0];
		end
	end

	// ------------------------------------------------------------ numerators
	logic signed [VNW-1:0] g3_a [6];
	logic signed [DDW-1:0] g3_b [6];
	logic signed [P3W-1:0] g3_p [6];
	logic                  g3_vld;
	logic [S3W-1:0]        g3_side;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			g3_a[i]   = VNW'($signed(v_s3[i*IW +: IW]));
			g3_b[i]   = dd_s3;
			g3_a[i+3] = vn_s3;
			g3_b[i+3] = DDW'(n_s3[i]);
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_num
		if (k == 0) begin : g_lead
			rvap_mul #(.WA(VNW), .WB(DDW), .CW(CW), .WS(S3W)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s3),
				.a_i(g3_a[k]), .b_i(g3_b[k]), .side_i({dd_s3, v_s3}),
				.vld_o(g3_vld), .p_o(g3_p[k]), .side_o(g3_side)
			);
		end else begin : g_rest
			rvap_mul #(.WA(VNW), .WB(DDW), .CW(CW), .WS(1)) u_mul (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s3),
				.a_i(g3_a[k]), .b_i(g3_b[k]), .side_i(1'b0),
				.vld_o(), .p_o(g3_p[k]), .side_o()
			);
		end
	end

	logic                  vld_s4;
	logic signed [MW-1:0]  m_s4 [3];
	logic [DDW-1:0]        dd_s4;
	logic [VPW-1:0]        v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= g3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s4[i] <= MW'(g3_p[i] - (g3_p[i+3] <<< 1));
			end
			dd_s4 <= g3_side[VPW +: DDW];
			v_s4  <= g3_side[VPW-1:0];
		end
	end

	// Round half away from zero: q = floor((2|m| + dd) / (2 dd)).
	logic                vld_s5;
	logic [RW-1:0]       num_s5 [3];
	logic [2:0]          neg_s5;
	logic [DW-1:0]       den_s5;
	logic                deg_s5;
	logic [VPW-1:0]      v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s5[i] <= m_s4[i][MW-1];
				num_s5[i] <= m_s4[i][MW-1] ?
					RW'(dd_s4) - (RW'(m_s4[i]) << 1) :
					RW'(dd_s4) + (RW'(m_s4[i]) << 1);
			end
			den_s5 <= dd_s4 << 1;
			deg_s5 <= (dd_s4 == '0);
			v_s5   <= v_s4;
		end
	end

	// ---------------------------------------------------------------- divide
	logic [QW-1:0]  q_d [3];
	logic           div_vld;
	logic [S4W-1:0] div_side;

	for (genvar k = 0; k < 3; k++) begin : g_quo
		if (k == 0) begin : g_lead
			rvap_div #(.RW(RW), .DW(DW), .QW(QW), .WS(S4W)) u_div (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s5),
				.num_i(num_s5[k]), .den_i(den_s5),
				.side_i({neg_s5, deg_s5, v_s5}),
				.vld_o(div_vld), .q_o(q_d[k]), .side_o(div_side)
			);
		end else begin : g_rest
			rvap_div #(.RW(RW), .DW(DW), .QW(QW), .WS(1)) u_div (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s5),
				.num_i(num_s5[k]), .den_i(den_s5), .side_i(1'b0),
				.vld_o(), .q_o(q_d[k]), .side_o()
			);
		end
	end

	// ---------------------------------------------------- sign and saturate
	logic signed [QW:0] sq [3];
	logic [IW-1:0]      rc [3];
	logic [2:0]         over;
	logic               deg_d;

	assign deg_d = div_side[VPW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq[i] = div_side[VPW+1+i] ? -$signed({1'b0, q_d[i]}) :
				$signed({1'b0, q_d[i]});
			over[i] = (sq[i][QW:IW-1] != '0) && (sq[i][QW:IW-1] != '1);
			if (deg_d) begin
				rc[i] = div_side[i*IW +: IW];
			end else if (over[i]) begin
				rc[i] = sq[i][QW] ? rvap_pkg::SAT_NEG : rvap_pkg::SAT_POS;
			end else begin
				rc[i] = sq[i][IW-1:0];
			end
		end
	end

	logic [IW-1:0] refl_q [3];
	logic          deg_q;
	logic          sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_q <= rc;
			deg_q  <= deg_d;
			sat_q  <= !deg_d && (over != '0);
		end
	end

	assign out_valid  = out_vld_q;
	assign refl_x     = refl_q[0];
	assign refl_y     = refl_q[1];
	assign refl_z     = refl_q[2];
	assign degenerate = deg_q;
	assign saturated  = sat_q;

endmodule

[hw/rtl/rvap_chk.sv]
// ----------------------------------------------------------------------------
// rvap_chk
// Port-level checks for the reflection unit, bound to its top level.
// ----------------------------------------------------------------------------
module rvap_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] refl_x,
	input logic [31:0] refl_y,
	input logic [31:0] refl_z,
	input logic        degenerate,
	input logic        saturated
);

	// A word that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(refl_x) &&
		$stable(refl_y) && $stable(refl_z) && $stable(degenerate))
		else $error("output word changed while stalled");

	// The pipeline moves as a whole, so a held word blocks the input.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	a_deg_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !saturated)
		else $error("degenerate word flagged as saturated");

	// A clipped word shows at least one rail value.
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		(refl_x == 32'h7fffffff || refl_x == 32'h80000000 ||
		refl_y == 32'h7fffffff || refl_y == 32'h80000000 ||
		refl_z == 32'h7fffffff || refl_z == 32'h80000000))
		else $error("saturated word without a rail value");

endmodule

bind reflect_vector_about_plane_unit rvap_chk u_rvap_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.refl_x(refl_x),
	.refl_y(refl_y),
	.refl_z(refl_z),
	.degenerate(degenerate),
	.saturated(saturated)
);
